// ===== rtl/sef_pkg.sv =====
// Shared types, constants and helpers for the stereo echo FIR mixer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sef_pkg;

  localparam int FIR_TAPS     = 8;
  localparam int TAP_W        = $clog2(FIR_TAPS);
  localparam int QUEUE_DEPTH  = 2;

  localparam int CTRL_MUTE_BIT   = 6;
  localparam int CTRL_WR_DIS_BIT = 5;
  localparam logic [7:0] CTRL_RESET = 8'hE0;

  localparam logic [15:0] RING_STEP = 16'd4;

  typedef enum logic [2:0] {
    REG_MAIN_VOLUME,
    REG_ECHO_VOLUME,
    REG_ECHO_FEEDBACK,
    REG_FIR_COEFFICIENTS,
    REG_ECHO_START_PAGE,
    REG_ECHO_DELAY,
    REG_CONTROL_FLAGS
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        main_volume;
    logic [15:0]        echo_volume;
    logic signed [7:0]  echo_feedback;
    logic [63:0]        fir_coefficients;
    logic [7:0]         echo_start_page;
    logic [3:0]         echo_delay;
    logic [7:0]         control_flags;
  } cfg_t;

  // One queued sample: mixes, ring reads and the ring addresses worked out up front.
  typedef struct packed {
    logic signed [15:0] main_left;
    logic signed [15:0] main_right;
    logic signed [15:0] send_left;
    logic signed [15:0] send_right;
    logic signed [15:0] read_left;
    logic signed [15:0] read_right;
    logic [15:0]        slot;
    logic [15:0]        next_read;
  } qent_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TAP,
    BK_MUL,
    BK_FIN,
    BK_DONE
  } bk_state_t;

  function automatic logic signed [15:0] clamp16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sef_queue.sv =====
// Small FIFO between the front and the back of the echo mixer.
// Depends on sef_pkg for the entry type.
`default_nettype none

module sef_queue #(
  parameter int DEPTH = sef_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sef_pkg::qent_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output sef_pkg::qent_t     head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sef_pkg::qent_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sef_front.sv =====
// Front end of the echo mixer: takes input beats, steps the echo ring offset
// and queues each sample with its ring addresses. Depends on sef_pkg.
`default_nettype none

module sef_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sef_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_main_mix_left,
  input  wire logic signed [15:0] in_main_mix_right,
  input  wire logic signed [15:0] in_echo_send_left,
  input  wire logic signed [15:0] in_echo_send_right,
  input  wire logic signed [15:0] in_ring_read_left,
  input  wire logic signed [15:0] in_ring_read_right,
  input  wire logic               q_full,
  output logic                    q_push,
  output sef_pkg::qent_t          q_data
);

  logic [15:0] offset_r, offset_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  page_r, page_nxt;

  logic [15:0] len_cur;
  logic [15:0] off_inc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    // The ring length is only reloaded when an item starts at the ring base.
    len_cur    = (offset_r == '0) ? {1'b0, cfg.echo_delay, 11'd0} : length_r;
    off_inc    = offset_r + sef_pkg::RING_STEP;
    offset_nxt = (off_inc >= len_cur) ? '0 : off_inc;
    length_nxt = len_cur;
    page_nxt   = cfg.echo_start_page;

    q_data.main_left  = in_main_mix_left;
    q_data.main_right = in_main_mix_right;
    q_data.send_left  = in_echo_send_left;
    q_data.send_right = in_echo_send_right;
    q_data.read_left  = in_ring_read_left;
    q_data.read_right = in_ring_read_right;
    q_data.slot       = {page_r, 8'h00} + offset_r;
    q_data.next_read  = {page_nxt, 8'h00} + offset_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      length_r <= '0;
      page_r   <= '0;
    end else if (q_push) begin
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      page_r   <= page_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sef_back.sv =====
// Back end of the echo mixer: eight-tap FIR over the echo history with one
// shared tap multiplier, then feedback and output mixing. Depends on sef_pkg.
`default_nettype none

module sef_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sef_pkg::cfg_t  cfg,
  input  wire logic           q_empty,
  input  wire sef_pkg::qent_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic signed [15:0]  out_dac_left,
  output logic signed [15:0]  out_dac_right,
  output logic signed [15:0]  out_ring_write_left,
  output logic signed [15:0]  out_ring_write_right,
  output logic                out_ring_write_enable,
  output logic [15:0]         out_ring_write_address,
  output logic [15:0]         out_next_read_address
);

  localparam int TW = sef_pkg::TAP_W;
  localparam int NT = sef_pkg::FIR_TAPS;
  localparam logic [TW-1:0] LAST_TAP = TW'(NT - 1);

  sef_pkg::bk_state_t state_r, state_nxt;

  logic signed [14:0] hist_l_r [NT];
  logic signed [14:0] hist_rt_r [NT];
  logic [TW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic          ch_r, ch_nxt;
  logic [15:0]   acc_r, acc_nxt;
  logic signed [15:0] echo_r, echo_nxt;
  logic signed [23:0] pm_r, pm_nxt;
  logic signed [23:0] pe_r, pe_nxt;
  logic signed [23:0] pf_r, pf_nxt;
  sef_pkg::qent_t item_r, item_nxt;
  logic signed [15:0] res_dac_r [2];
  logic signed [15:0] res_wr_r [2];
  logic signed [15:0] dac_nxt, wr_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [15:0] o_dac_l_r, o_dac_rt_r, o_wr_l_r, o_wr_rt_r;
  logic o_we_r;
  logic [15:0] o_addr_r, o_next_r;

  logic          hist_we;
  logic [TW-1:0] tap_idx;
  logic signed [14:0] h_sel;
  logic signed [7:0]  coef;
  logic signed [22:0] prod;
  logic signed [16:0] tap_v;
  logic signed [17:0] esum;
  logic signed [15:0] eclamp;
  logic signed [15:0] mm, snd, fbv;
  logic signed [7:0]  mv, ev;
  logic signed [17:0] dsum, wsum;
  logic signed [15:0] dclamp, wclamp;
  logic out_load;

  // Shared tap datapath: tap k reads history entry pos+k+1, tap 0 being the oldest.
  always_comb begin
    tap_idx = pos_r + k_r + TW'(1);
    h_sel   = ch_r ? hist_rt_r[tap_idx] : hist_l_r[tap_idx];
    coef    = signed'(cfg.fir_coefficients[{k_r, 3'b000} +: 8]);
    prod    = h_sel * coef;
    tap_v   = prod[22:6];
    esum    = 18'(signed'(acc_r)) + 18'(signed'(tap_v[15:0]));
    eclamp  = sef_pkg::clamp16(esum);

    mm  = ch_r ? item_r.main_right : item_r.main_left;
    snd = ch_r ? item_r.send_right : item_r.send_left;
    mv  = signed'(ch_r ? cfg.main_volume[15:8] : cfg.main_volume[7:0]);
    ev  = signed'(ch_r ? cfg.echo_volume[15:8] : cfg.echo_volume[7:0]);

    dsum   = 18'(signed'(pm_r[23:7])) + 18'(signed'(pe_r[23:7]));
    dclamp = sef_pkg::clamp16(dsum);
    fbv    = signed'(pf_r[22:7]);
    wsum   = 18'(snd) + 18'(fbv);
    wclamp = sef_pkg::clamp16(wsum);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sef_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = sef_pkg::BK_TAP;
        end
      end
      sef_pkg::BK_TAP: begin
        if (k_r == LAST_TAP) begin
          state_nxt = sef_pkg::BK_MUL;
        end
      end
      sef_pkg::BK_MUL: begin
        state_nxt = sef_pkg::BK_FIN;
      end
      sef_pkg::BK_FIN: begin
        state_nxt = ch_r ? sef_pkg::BK_DONE : sef_pkg::BK_TAP;
      end
      sef_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = sef_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sef_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    hist_we       = 1'b0;
    out_load      = 1'b0;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    ch_nxt        = ch_r;
    acc_nxt       = acc_r;
    echo_nxt      = echo_r;
    pm_nxt        = pm_r;
    pe_nxt        = pe_r;
    pf_nxt        = pf_r;
    item_nxt      = item_r;
    dac_nxt       = dclamp;
    wr_nxt        = {wclamp[15:1], 1'b0};
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      sef_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          hist_we  = 1'b1;
          pos_nxt  = pos_r + TW'(1);
          item_nxt = q_head;
          k_nxt    = '0;
          ch_nxt   = 1'b0;
          acc_nxt  = '0;
        end
      end
      sef_pkg::BK_TAP: begin
        if (k_r == LAST_TAP) begin
          // Older taps wrap to 16 bits; the newest tap is added before clamping.
          echo_nxt = {eclamp[15:1], 1'b0};
        end else begin
          acc_nxt = acc_r + tap_v[15:0];
          k_nxt   = k_r + TW'(1);
        end
      end
      sef_pkg::BK_MUL: begin
        pm_nxt = mm * mv;
        pe_nxt = echo_r * ev;
        pf_nxt = echo_r * cfg.echo_feedback;
      end
      sef_pkg::BK_FIN: begin
        if (cfg.control_flags[sef_pkg::CTRL_MUTE_BIT]) begin
          dac_nxt = '0;
        end
        ch_nxt  = 1'b1;
        k_nxt   = '0;
        acc_nxt = '0;
      end
      sef_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sef_pkg::BK_IDLE;
      pos_r       <= '0;
      k_r         <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        hist_l_r[i]  <= '0;
        hist_rt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      if (hist_we) begin
        hist_l_r[pos_nxt]  <= q_head.read_left[15:1];
        hist_rt_r[pos_nxt] <= q_head.read_right[15:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    echo_r <= echo_nxt;
    pm_r   <= pm_nxt;
    pe_r   <= pe_nxt;
    pf_r   <= pf_nxt;
    item_r <= item_nxt;
    if (state_r == sef_pkg::BK_FIN) begin
      res_dac_r[ch_r] <= dac_nxt;
      res_wr_r[ch_r]  <= wr_nxt;
    end
    if (out_load) begin
      o_dac_l_r  <= res_dac_r[0];
      o_dac_rt_r <= res_dac_r[1];
      o_wr_l_r   <= res_wr_r[0];
      o_wr_rt_r  <= res_wr_r[1];
      o_we_r     <= !cfg.control_flags[sef_pkg::CTRL_WR_DIS_BIT];
      o_addr_r   <= item_r.slot;
      o_next_r   <= item_r.next_read;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_dac_left           = o_dac_l_r;
  assign out_dac_right          = o_dac_rt_r;
  assign out_ring_write_left    = o_wr_l_r;
  assign out_ring_write_right   = o_wr_rt_r;
  assign out_ring_write_enable  = o_we_r;
  assign out_ring_write_address = o_addr_r;
  assign out_next_read_address  = o_next_r;

endmodule

`default_nettype wire

// ===== rtl/stereo_echo_fir_mixer.sv =====
// Each input beat is queued; the back end's single tap multiplier then steps
// through eight taps per channel plus the mixing steps. The back end finishes
// each sample before taking the next, and waits while a result is untaken.
// A two-entry queue takes further input beats while the back end is busy.
// Reset (synchronous, rst_n low) clears the FIR history, the ring offset and
// length, all handshakes, and loads the control flags with 0xE0.
`default_nettype none

module stereo_echo_fir_mixer #(
  parameter int QUEUE_DEPTH = sef_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_main_mix_left,
  input  wire logic signed [15:0] in_main_mix_right,
  input  wire logic signed [15:0] in_echo_send_left,
  input  wire logic signed [15:0] in_echo_send_right,
  input  wire logic signed [15:0] in_ring_read_left,
  input  wire logic signed [15:0] in_ring_read_right,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_dac_left,
  output logic signed [15:0]      out_dac_right,
  output logic signed [15:0]      out_ring_write_left,
  output logic signed [15:0]      out_ring_write_right,
  output logic                    out_ring_write_enable,
  output logic [15:0]             out_ring_write_address,
  output logic [15:0]             out_next_read_address
);

  sef_pkg::cfg_t  cfg_r;
  sef_pkg::qent_t q_data, q_head;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.main_volume      <= '0;
      cfg_r.echo_volume      <= '0;
      cfg_r.echo_feedback    <= '0;
      cfg_r.fir_coefficients <= '0;
      cfg_r.echo_start_page  <= '0;
      cfg_r.echo_delay       <= '0;
      cfg_r.control_flags    <= sef_pkg::CTRL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sef_pkg::reg_idx_t'(cfg_index))
        sef_pkg::REG_MAIN_VOLUME:      cfg_r.main_volume      <= cfg_data[15:0];
        sef_pkg::REG_ECHO_VOLUME:      cfg_r.echo_volume      <= cfg_data[15:0];
        sef_pkg::REG_ECHO_FEEDBACK:    cfg_r.echo_feedback    <= cfg_data[7:0];
        sef_pkg::REG_FIR_COEFFICIENTS: cfg_r.fir_coefficients <= cfg_data;
        sef_pkg::REG_ECHO_START_PAGE:  cfg_r.echo_start_page  <= cfg_data[7:0];
        sef_pkg::REG_ECHO_DELAY:       cfg_r.echo_delay       <= cfg_data[3:0];
        sef_pkg::REG_CONTROL_FLAGS:    cfg_r.control_flags    <= cfg_data[7:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  sef_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_main_mix_left   (in_main_mix_left),
    .in_main_mix_right  (in_main_mix_right),
    .in_echo_send_left  (in_echo_send_left),
    .in_echo_send_right (in_echo_send_right),
    .in_ring_read_left  (in_ring_read_left),
    .in_ring_read_right (in_ring_read_right),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_data)
  );

  sef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sef_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_empty                (q_empty),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_dac_left           (out_dac_left),
    .out_dac_right          (out_dac_right),
    .out_ring_write_left    (out_ring_write_left),
    .out_ring_write_right   (out_ring_write_right),
    .out_ring_write_enable  (out_ring_write_enable),
    .out_ring_write_address (out_ring_write_address),
    .out_next_read_address  (out_next_read_address)
  );

endmodule

`default_nettype wire

// ===== rtl/sef_checker.sv =====
// Port-level checker for the stereo echo FIR mixer, bound to the top level.
// Depends on sef_pkg for the register index names.
`default_nettype none

module sef_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [2:0]         cfg_index,
  input wire logic [63:0]        cfg_data,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_dac_left,
  input wire logic signed [15:0] out_dac_right,
  input wire logic signed [15:0] out_ring_write_left,
  input wire logic signed [15:0] out_ring_write_right,
  input wire logic               out_ring_write_enable,
  input wire logic [15:0]        out_ring_write_address,
  input wire logic [15:0]        out_next_read_address
);

  logic [7:0]  pend_r;
  logic        seen_r;
  logic [15:0] last_read_r;
  logic        mute_r;
  logic        wdis_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
      mute_r <= 1'b1;
      wdis_r <= 1'b1;
    end else begin
      pend_r <= pend_r + 8'(in_acc) - 8'(out_acc);
      if (out_acc) begin
        seen_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready &&
          cfg_index == sef_pkg::REG_CONTROL_FLAGS) begin
        mute_r <= cfg_data[sef_pkg::CTRL_MUTE_BIT];
        wdis_r <= cfg_data[sef_pkg::CTRL_WR_DIS_BIT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_read_r <= out_next_read_address;
    end
  end

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_left) &&
      $stable(out_dac_right) && $stable(out_ring_write_left) &&
      $stable(out_ring_write_right) && $stable(out_ring_write_address) &&
      $stable(out_next_read_address) && $stable(out_ring_write_enable))
    else $error("result beat changed while stalled");

  // No result without an input beat still owed one.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result shown with no outstanding input");

  // Each slot is where the previous result told the ring to read.
  a_addr_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_ring_write_address == last_read_r)
    else $error("ring slot does not follow the announced read address");

  // Write enable and mute follow the control flags.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ring_write_enable == !wdis_r) &&
      (!mute_r || (out_dac_left == 16'sd0 && out_dac_right == 16'sd0)))
    else $error("control flags not applied to result");

endmodule

bind stereo_echo_fir_mixer sef_checker u_sef_checker (.*);

`default_nettype wire

// ===== dv/stereo_echo_fir_mixer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stereo echo FIR mixer: a directed table, then paced random
// samples, each result compared to a typed-in answer or a cycle-free echo predictor.
// Depends on sef_pkg and the stereo_echo_fir_mixer top level.

module stereo_echo_fir_mixer_test;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [15:0] main_l;
    logic signed [15:0] main_r;
    logic signed [15:0] send_l;
    logic signed [15:0] send_r;
    logic signed [15:0] read_l;
    logic signed [15:0] read_r;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] dac_l;
    logic signed [15:0] dac_r;
    logic signed [15:0] wr_l;
    logic signed [15:0] wr_r;
    logic               wr_en;
    logic [15:0]        wr_addr;
    logic [15:0]        rd_addr;
  } mix_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] value;
    sample_t     s;
    bit          pinned;
    mix_t        want;
  } plan_row_t;

  typedef enum {SET_RANDOM, SET_HIGH, SET_LOW} setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_main_mix_left = '0;
  logic signed [15:0] in_main_mix_right = '0;
  logic signed [15:0] in_echo_send_left = '0;
  logic signed [15:0] in_echo_send_right = '0;
  logic signed [15:0] in_ring_read_left = '0;
  logic signed [15:0] in_ring_read_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_dac_left;
  logic signed [15:0] out_dac_right;
  logic signed [15:0] out_ring_write_left;
  logic signed [15:0] out_ring_write_right;
  logic out_ring_write_enable;
  logic [15:0] out_ring_write_address;
  logic [15:0] out_next_read_address;

  // Travels with each input beat so the monitor knows whether the row has a typed-in answer.
  bit beat_pinned = 1'b0;
  mix_t beat_want = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int failures = 0;
  int directed_count = 0;

  // Predictor state: register copy, FIR history and ring pointers.
  sef_pkg::cfg_t shadow_cfg;
  int          fir_hist [8][2];
  logic [2:0]  hist_pos;
  logic [15:0] ring_off;
  logic [15:0] ring_len;
  logic [7:0]  ring_page;
  mix_t        awaited_mixes [$];
  plan_row_t   plan [$];

  stereo_echo_fir_mixer dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int wrap16(input int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic int fir_tap(input int k, input int ch);
    logic signed [7:0] c;
    c = shadow_cfg.fir_coefficients[8*k +: 8];
    return (fir_hist[(hist_pos + k + 1) & 7][ch] * c) >>> 6;
  endfunction

  function automatic mix_t mix_sample(input sample_t s);
    mix_t r;
    int mains [2];
    int sends [2];
    int echo_in [2];
    int acc;
    int fb;
    int dac;
    int wr;
    logic [15:0] slot;
    logic signed [7:0] mv;
    logic signed [7:0] ev;
    logic signed [7:0] gain;
    mains[0] = int'(s.main_l);
    mains[1] = int'(s.main_r);
    sends[0] = int'(s.send_l);
    sends[1] = int'(s.send_r);
    hist_pos = hist_pos + 3'd1;
    slot = {ring_page, 8'h00} + ring_off;
    fir_hist[hist_pos][0] = int'(s.read_l) >>> 1;
    fir_hist[hist_pos][1] = int'(s.read_r) >>> 1;
    // The older seven taps wrap together; the newest tap wraps on its own before the clamp.
    for (int ch = 0; ch < 2; ch++) begin
      acc = 0;
      for (int k = 0; k < sef_pkg::FIR_TAPS - 1; k++) acc += fir_tap(k, ch);
      acc = wrap16(acc) + wrap16(fir_tap(sef_pkg::FIR_TAPS - 1, ch));
      echo_in[ch] = sat16(acc) & ~1;
    end
    gain = shadow_cfg.echo_feedback;
    for (int ch = 0; ch < 2; ch++) begin
      mv = shadow_cfg.main_volume[8*ch +: 8];
      ev = shadow_cfg.echo_volume[8*ch +: 8];
      fb = wrap16((echo_in[ch] * gain) >>> 7);
      dac = sat16(((mains[ch] * mv) >>> 7) + ((echo_in[ch] * ev) >>> 7));
      if (shadow_cfg.control_flags[sef_pkg::CTRL_MUTE_BIT]) dac = 0;
      wr = sat16(sends[ch] + fb) & ~1;
      if (ch == 0) begin
        r.dac_l = 16'(dac);
        r.wr_l = 16'(wr);
      end else begin
        r.dac_r = 16'(dac);
        r.wr_r = 16'(wr);
      end
    end
    r.wr_en = !shadow_cfg.control_flags[sef_pkg::CTRL_WR_DIS_BIT];
    r.wr_addr = slot;
    // The ring length is only picked up when the offset starts from zero.
    if (ring_off == 16'd0) ring_len = {1'b0, shadow_cfg.echo_delay, 11'd0};
    ring_off = ring_off + sef_pkg::RING_STEP;
    if (ring_off >= ring_len) ring_off = '0;
    ring_page = shadow_cfg.echo_start_page;
    r.rd_addr = {ring_page, 8'h00} + ring_off;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 10) $display("%s mismatch: expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    mix_t fresh;
    mix_t oldest;
    if (!rst_n) begin
      shadow_cfg = '0;
      shadow_cfg.control_flags = sef_pkg::CTRL_RESET;
      foreach (fir_hist[i, j]) fir_hist[i][j] = 0;
      hist_pos = '0;
      ring_off = '0;
      ring_len = '0;
      ring_page = '0;
      awaited_mixes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          sef_pkg::REG_MAIN_VOLUME: shadow_cfg.main_volume = cfg_data[15:0];
          sef_pkg::REG_ECHO_VOLUME: shadow_cfg.echo_volume = cfg_data[15:0];
          sef_pkg::REG_ECHO_FEEDBACK: shadow_cfg.echo_feedback = cfg_data[7:0];
          sef_pkg::REG_FIR_COEFFICIENTS: shadow_cfg.fir_coefficients = cfg_data;
          sef_pkg::REG_ECHO_START_PAGE: shadow_cfg.echo_start_page = cfg_data[7:0];
          sef_pkg::REG_ECHO_DELAY: shadow_cfg.echo_delay = cfg_data[3:0];
          sef_pkg::REG_CONTROL_FLAGS: shadow_cfg.control_flags = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fresh = mix_sample({in_main_mix_left, in_main_mix_right, in_echo_send_left,
                            in_echo_send_right, in_ring_read_left, in_ring_read_right});
        if (beat_pinned) fresh = beat_want;
        awaited_mixes.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_mixes.size() == 0) begin
          failures++;
          if (failures <= 10) $display("result beat arrived with no sample awaiting it");
        end else begin
          oldest = awaited_mixes.pop_front();
          check_field("dac_left", oldest.dac_l, out_dac_left);
          check_field("dac_right", oldest.dac_r, out_dac_right);
          check_field("ring_write_left", oldest.wr_l, out_ring_write_left);
          check_field("ring_write_right", oldest.wr_r, out_ring_write_right);
          check_field("ring_write_enable", 16'(oldest.wr_en), 16'(out_ring_write_enable));
          check_field("ring_write_address", oldest.wr_addr, out_ring_write_address);
          check_field("next_read_address", oldest.rd_addr, out_next_read_address);
        end
      end
    end
  end

  function automatic sample_t smp(input int ml, mr, sl, sr, rl, rr);
    return {ml[15:0], mr[15:0], sl[15:0], sr[15:0], rl[15:0], rr[15:0]};
  endfunction

  function automatic mix_t mix_of(input int dl, dr, wl, wr, en, wa, ra);
    return {dl[15:0], dr[15:0], wl[15:0], wr[15:0], en[0], wa[15:0], ra[15:0]};
  endfunction

  function automatic plan_row_t data_row(input sample_t s);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.value = '0;
    r.s = s;
    r.pinned = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(input sample_t s, input mix_t want);
    plan_row_t r;
    r = data_row(s);
    r.pinned = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] idx, input logic [63:0] value);
    plan_row_t r;
    r = data_row('0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Lowers the sample valid and holds off until every accepted sample has its result back.
  task automatic settle_results();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input bit pinned, input mix_t want);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_main_mix_left <= s.main_l;
    in_main_mix_right <= s.main_r;
    in_echo_send_left <= s.send_l;
    in_echo_send_right <= s.send_r;
    in_ring_read_left <= s.read_l;
    in_ring_read_right <= s.read_r;
    beat_pinned <= pinned;
    beat_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it once its run of writes is done.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    logic [63:0] keep;
    settle_results();
    case (idx)
      sef_pkg::REG_MAIN_VOLUME, sef_pkg::REG_ECHO_VOLUME: keep = 64'hFFFF;
      sef_pkg::REG_ECHO_FEEDBACK, sef_pkg::REG_ECHO_START_PAGE,
      sef_pkg::REG_CONTROL_FLAGS: keep = 64'hFF;
      sef_pkg::REG_ECHO_DELAY: keep = 64'hF;
      default: keep = '1;
    endcase
    // Bits above the register width carry noise; the block must drop them.
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (value & keep) | ({$urandom, $urandom} & ~keep);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_setting(input setting_t style);
    logic [63:0] v [7];
    sef_pkg::reg_idx_t ri;
    case (style)
      SET_HIGH: v = '{64'h7F7F, 64'h7F7F, 64'h7F, {8{8'h7F}}, 64'hFF, 64'hF, 64'h00};
      SET_LOW: v = '{64'h8080, 64'h8080, 64'h80, {8{8'h80}}, 64'h00, 64'h1, 64'h1F};
      default: begin
        foreach (v[i]) v[i] = {$urandom, $urandom};
        v[sef_pkg::REG_ECHO_DELAY] = 64'($urandom_range(15));
      end
    endcase
    ri = ri.first();
    do begin
      write_reg(ri, v[ri]);
      ri = ri.next();
    end while (ri != ri.first());
    cfg_valid <= 1'b0;
  endtask

  initial begin : run
    setting_t style;
    int len;
    // Straight out of reset: muted, writes disabled, zero ring length, no filter taps.
    plan.push_back(pinned_row(smp(0, 0, 0, 0, 0, 0), mix_of(0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(pinned_row(smp(32767, -32768, 32767, -32768, 32767, -32768),
                              mix_of(0, 0, 32766, -32768, 0, 0, 0)));
    plan.push_back(pinned_row(smp(-1, 1, -1, 1, -1, 1), mix_of(0, 0, -2, 0, 0, 0, 0)));
    plan.push_back(pinned_row(smp(-32768, 32767, -32768, 32767, -32768, 32767),
                              mix_of(0, 0, -32768, 32766, 0, 0, 0)));
    // Extreme gains and taps with full-scale negative history overflow both tap sums;
    // the top page puts the ring slots at the very top of the address space.
    plan.push_back(cfg_row(REG_UNUSED, '1));
    plan.push_back(cfg_row(sef_pkg::REG_MAIN_VOLUME, 64'h807F));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_VOLUME, 64'h7F80));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_FEEDBACK, 64'h80));
    plan.push_back(cfg_row(sef_pkg::REG_FIR_COEFFICIENTS, {8{8'h80}}));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_START_PAGE, 64'hFF));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_DELAY, 64'hF));
    plan.push_back(cfg_row(sef_pkg::REG_CONTROL_FLAGS, 64'h00));
    repeat (3) plan.push_back(data_row(smp(32767, -32768, -32768, 32767, -32768, -32768)));
    repeat (3) plan.push_back(data_row(smp(-32768, 32767, 32767, -32768, -32768, -32768)));
    plan.push_back(cfg_row(sef_pkg::REG_MAIN_VOLUME, 64'h7F80));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_VOLUME, 64'h807F));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_FEEDBACK, 64'h7F));
    plan.push_back(cfg_row(sef_pkg::REG_FIR_COEFFICIENTS, {8{8'h7F}}));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_START_PAGE, 64'h00));
    plan.push_back(cfg_row(sef_pkg::REG_ECHO_DELAY, 64'h0));
    plan.push_back(cfg_row(sef_pkg::REG_CONTROL_FLAGS, 64'hFF));
    repeat (3) begin
      plan.push_back(data_row(smp(-32768, 32767, -32768, 32767, 32767, 32767)));
      plan.push_back(data_row(smp(32767, -32768, 32767, -32768, -32768, 32767)));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 18;
    rx_idle_pct = 67;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_reg(plan[r].idx, plan[r].value);
        if (r + 1 == plan.size() || !plan[r + 1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_sample(plan[r].s, plan[r].pinned, plan[r].want);
        directed_count++;
      end
    end

    for (int b = 0; b < 6; b++) begin
      tx_idle_pct = (b < 2) ? 18 : (b < 4) ? 67 : 0;
      rx_idle_pct = (b < 2) ? 67 : (b < 4) ? 18 : 0;
      case (b)
        1, 5: style = SET_HIGH;
        3: style = SET_LOW;
        default: style = SET_RANDOM;
      endcase
      // The low setting uses the shortest ring, so it runs long enough to wrap the offset.
      len = (b == 3) ? 560 : 195;
      program_setting(style);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(99) == 0) settle_results();
        send_sample({pick16(), pick16(), pick16(), pick16(), pick16(), pick16()}, 1'b0, '0);
      end
    end

    settle_results();
    repeat (40) @(posedge clk);
    failures += awaited_mixes.size();
    $display("Sent %0d samples (%0d from the directed table) with %0d register writes,",
             items_sent, directed_count, reg_writes);
    $display("paced sender-heavy, receiver-heavy and free-running; %0d failures.", failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sef_pkg.sv
rtl/sef_queue.sv
rtl/sef_front.sv
rtl/sef_back.sv
rtl/stereo_echo_fir_mixer.sv
rtl/sef_checker.sv
dv/stereo_echo_fir_mixer_test.sv
